[rtl/hsd_pkg.sv]
package hsd_pkg;

  // Fixed port widths
  localparam int VAL_W = 16;

  // Defaults for the top-level parameters
  localparam int CAP_DEF   = 64;
  localparam int VBITS_DEF = 16;

  // Outcome of one sift-down compare
  typedef struct packed {
    logic move;   // a child is smaller than the sifted value
    logic right;  // that child is the right one
  } sel_t;

endpackage

[rtl/hsd_store.sv]
module hsd_store #(
  parameter int DEPTH = hsd_pkg::CAP_DEF,
  parameter int W     = hsd_pkg::VAL_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [W-1:0]             rdata_a,
  output logic [W-1:0]             rdata_b
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/hsd_sel.sv]
module hsd_sel #(
  parameter int W = hsd_pkg::VAL_W
) (
  input  logic [W-1:0]  cur,
  input  logic [W-1:0]  left_val,
  input  logic [W-1:0]  right_val,
  input  logic          left_ok,
  input  logic          right_ok,
  output hsd_pkg::sel_t sel
);

  import hsd_pkg::*;

  logic         take_l;
  logic [W-1:0] small_val;

  // ties keep the parent, then prefer the left child
  always_comb begin
    take_l    = left_ok && (left_val < cur);
    small_val = take_l ? left_val : cur;
    sel.right = right_ok && (right_val < small_val);
    sel.move  = take_l || sel.right;
  end

endmodule

[rtl/heap_sort_descending.sv]
// Heap sorter: values are loaded one request per cycle on the input channel
// (in_valid/in_stall); the request with final_item set closes the set. Up to
// CAPACITY values are held, later ones are dropped and every result of that
// run then carries overflowed. After the set closes the block stalls its input,
// builds a min-heap in a dual-read-port store, then repeatedly moves the root to
// the end of the shrinking heap and sifts the new root down, leaving the store
// in descending order; the values then stream out largest first, last_result
// marking the final one. Each sift-down of the heap build first reads the value
// to sift, then latches it while reading its children (the setup), then descends
// the heap level by level (one compare of two children per cycle, bounded by the
// store's two read ports) and writes the sifted value home where it stops. Each
// root extraction reads the root and the heap end, writes the root to the heap
// end and shrinks the heap, then runs the same sift without the setup; each result
// is read, loaded into the output register and held until it is taken.
// A run of one value is not sorted, only emitted. Only the low VALUE_BITS bits
// of value are kept (at most 16 matter, as the port is 16 bits wide).
module heap_sort_descending #(
  parameter int CAPACITY   = hsd_pkg::CAP_DEF,
  parameter int VALUE_BITS = hsd_pkg::VBITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // load channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [hsd_pkg::VAL_W-1:0] value,
  input  logic                      final_item,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [hsd_pkg::VAL_W-1:0] sorted_value,
  output logic                      last_result,
  output logic                      overflowed
);

  import hsd_pkg::*;

  localparam int AW = $clog2(CAPACITY);        // store index
  localparam int CW = $clog2(CAPACITY + 1);    // element count
  localparam int SW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;  // kept bits

  // sequencer states
  localparam logic [3:0] S_LOAD    = 4'd0;  // taking requests
  localparam logic [3:0] S_FETCH   = 4'd1;  // read the value to sift
  localparam logic [3:0] S_LCUR    = 4'd2;  // latch it, read its children
  localparam logic [3:0] S_CMP     = 4'd3;  // one sift level per cycle
  localparam logic [3:0] S_SWAP_RD = 4'd4;  // read root and heap end
  localparam logic [3:0] S_SWAP_WR = 4'd5;  // root to heap end, shrink heap
  localparam logic [3:0] S_ORD     = 4'd6;  // read first result
  localparam logic [3:0] S_OLD     = 4'd7;  // load output register
  localparam logic [3:0] S_OWAIT   = 4'd8;  // hold result until taken

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic [AW-1:0] heap_end;
  logic [AW-1:0] top;      // heapify position during build
  logic [AW-1:0] pos;      // hole position while sifting
  logic [SW-1:0] cur;      // value being sifted
  logic [AW-1:0] idx;      // output position
  logic          building;

  // store ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [SW-1:0] rd_a;
  logic [SW-1:0] rd_b;

  // compare unit
  sel_t          sel;
  logic [AW+1:0] lc;
  logic [AW+1:0] rc;
  logic          left_ok;
  logic          right_ok;
  logic [AW+1:0] child;
  logic [SW-1:0] child_val;
  logic [AW+1:0] base_lc;
  logic [AW-1:0] base;

  logic          in_acc;
  logic          out_acc;
  logic          room;
  logic [CW-1:0] n_items;

  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign room      = (count < CW'(CAPACITY));
  assign n_items   = room ? count + CW'(1) : count;

  // children of the current hole, checked against the live heap end
  assign lc        = {1'b0, pos, 1'b1};
  assign rc        = lc + (AW+2)'(1);
  assign left_ok   = (lc <= (AW+2)'(heap_end));
  assign right_ok  = (rc <= (AW+2)'(heap_end));
  assign child     = sel.right ? rc : lc;
  assign child_val = sel.right ? rd_b : rd_a;

  hsd_sel #(.W(SW)) u_sel (
    .cur       (cur),
    .left_val  (rd_a),
    .right_val (rd_b),
    .left_ok   (left_ok),
    .right_ok  (right_ok),
    .sel       (sel)
  );

  hsd_store #(.DEPTH(CAPACITY), .W(SW)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // node whose children get read for the next sift level
  always_comb begin
    case (state)
      S_LCUR:  base = top;
      S_CMP:   base = child[AW-1:0];
      default: base = '0;
    endcase
  end
  assign base_lc = {1'b0, base, 1'b1};

  always_comb begin
    raddr_a = base_lc[AW-1:0];
    raddr_b = AW'(base_lc + (AW+2)'(1));
    case (state)
      S_FETCH: begin
        raddr_a = top;
      end
      S_SWAP_RD: begin
        raddr_a = '0;
        raddr_b = heap_end;
      end
      S_ORD: begin
        raddr_a = '0;
      end
      S_OWAIT: begin
        raddr_a = idx + AW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = value[SW-1:0];
    case (state)
      S_LOAD: begin
        we = in_acc && room;
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = pos;
        wdata = sel.move ? child_val : cur;
      end
      S_SWAP_WR: begin
        we    = 1'b1;
        waddr = heap_end;
        wdata = rd_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      heap_end  <= '0;
      building  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            count <= n_items;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (final_item) begin
              idx <= '0;
              if (n_items < CW'(2)) begin
                state <= S_ORD;
              end else begin
                heap_end <= AW'(n_items - CW'(1));
                top      <= AW'((n_items >> 1) - CW'(1));
                building <= 1'b1;
                state    <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          state <= S_LCUR;
        end
        S_LCUR: begin
          cur   <= rd_a;
          pos   <= top;
          state <= S_CMP;
        end
        S_CMP: begin
          if (sel.move) begin
            pos <= child[AW-1:0];
          end else if (building) begin
            if (top == '0) begin
              building <= 1'b0;
              state    <= S_SWAP_RD;
            end else begin
              top   <= top - AW'(1);
              state <= S_FETCH;
            end
          end else if (heap_end != '0) begin
            state <= S_SWAP_RD;
          end else begin
            idx   <= '0;
            state <= S_ORD;
          end
        end
        S_SWAP_RD: begin
          state <= S_SWAP_WR;
        end
        S_SWAP_WR: begin
          cur      <= rd_b;
          pos      <= '0;
          heap_end <= heap_end - AW'(1);
          state    <= S_CMP;
        end
        S_ORD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          sorted_value <= VAL_W'(rd_a);
          last_result  <= (CW'(idx) == count - CW'(1));
          overflowed   <= dropped;
          out_valid    <= 1'b1;
          state        <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (last_result) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_OLD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // the store never claims more entries than it has
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  // a result is only presented from the output hold state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OWAIT)
    else $error("result valid outside output state");

  // closing a set stops the load channel at once
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    in_acc && final_item |=> in_stall)
    else $error("input not stalled after final request");

  // taking the last result clears the set
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    out_acc && last_result |=> count == '0 && !dropped && !in_stall)
    else $error("set not cleared after last result");

  // the heap always lies inside the loaded elements while sorting
  a_heap_inside: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> CW'(heap_end) < count)
    else $error("heap end beyond loaded elements");

endmodule

[dv/heap_sort_descending_tb.sv]
module heap_sort_descending_tb;

  import hsd_pkg::*;

  // Block configuration under test: full-size store, full-width values.
  localparam int CAP   = CAP_DEF;
  localparam int VBITS = VBITS_DEF;
  localparam logic [VAL_W-1:0] VAL_MASK = {VAL_W{1'b1}} >> (VAL_W - VBITS);

  // Cycles with no request moving on either side before the run is called hung.
  // Worst quiet stretch: a full 64-entry sort after the HOLD_CYCLES output hold,
  // so the limit is several times that.
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  // One expected result of a sorted run.
  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             last;
    logic             ovf;
  } sorted_res_t;

  // Directed stimulus row. Rows with typed set carry their result inline;
  // those are single-element runs, where the answer is the input itself.
  typedef struct packed {
    logic [VAL_W-1:0] v;
    logic             fin;
    logic             typed;
    logic [VAL_W-1:0] t_val;
    logic             t_last;
    logic             t_ovf;
  } dir_row_t;

  localparam int DIR_N = 19;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // single-element runs straight after reset: emitted unsorted, last set
    '{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0},
    '{16'h8000, 1'b1, 1'b1, 16'h8000, 1'b1, 1'b0},
    '{16'h0001, 1'b1, 1'b1, 16'h0001, 1'b1, 1'b0},
    // two elements, already ascending
    '{16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h0002, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // three elements with both extremes
    '{16'h0005, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // all equal
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h7FFF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // seven elements, ties and extremes, full bottom heap level
    '{16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h00FF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'hFF00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{16'h0003, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] value = '0;
  logic             final_item = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] sorted_value;
  logic             last_result;
  logic             overflowed;

  always #2 clk = ~clk;

  heap_sort_descending #(
    .CAPACITY  (CAP),
    .VALUE_BITS(VBITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .last_result (last_result),
    .overflowed  (overflowed)
  );

  // Idle rates of the two sides, changed by the stimulus between phases.
  int src_idle_pct = 0;
  int stall_pct    = 0;
  bit hold_req     = 1'b0;

  // Predictor state: values of the open set, in arrival order, plus the drop flag.
  logic [VAL_W-1:0] held_vals [CAP];
  int               held_n      = 0;
  bit               set_dropped = 1'b0;

  // Results the block still owes, oldest first.
  sorted_res_t pending_sorted[$];

  int errors         = 0;
  int items_sent     = 0;
  int sets_closed    = 0;
  int results_seen   = 0;
  int overflow_sets  = 0;
  int biggest_set    = 0;

  // Take one accepted value into the open set. On the closing request, rank the
  // set largest first and queue one result per held value (unless the caller
  // supplies the result itself). Values past capacity only raise the drop flag.
  task automatic rank_descending(input logic [VAL_W-1:0] v, input logic fin,
                                 input bit emit);
    logic [VAL_W-1:0] key;
    sorted_res_t      r;
    int               a;
    int               b;
    if (held_n < CAP) begin
      held_vals[held_n] = v & VAL_MASK;
      held_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (fin) begin
      // insertion sort, descending; equal values are indistinguishable
      for (a = 1; a < held_n; a++) begin
        key = held_vals[a];
        b = a;
        while (b > 0 && held_vals[b-1] < key) begin
          held_vals[b] = held_vals[b-1];
          b--;
        end
        held_vals[b] = key;
      end
      if (emit) begin
        for (a = 0; a < held_n; a++) begin
          r.val  = held_vals[a];
          r.last = (a == held_n - 1);
          r.ovf  = set_dropped;
          pending_sorted.push_back(r);
        end
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      if (held_n > biggest_set) biggest_set = held_n;
      held_n      = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Offer one request and hold it until the block takes it. Random gaps go in
  // front; payload only changes with valid low or right after acceptance.
  task automatic send_request(input logic [VAL_W-1:0] v, input logic fin,
                              input bit typed, input sorted_res_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    final_item <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    rank_descending(v, fin, !typed);
    if (typed) pending_sorted.push_back(typed_res);
  endtask

  // Mostly full-range values; extremes and a narrow band for ties now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return VAL_W'($urandom_range(3));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int small_set_size();
    if ($urandom_range(99) < 15) return 1;
    return $urandom_range(12, 2);
  endfunction

  task automatic send_set(input int n);
    sorted_res_t none;
    int          k;
    none = '0;
    for (k = 0; k < n; k++) send_request(pick_value(), k == n - 1, 1'b0, none);
  endtask

  // Result side: random stall, plus one long hold on request so that a run backs
  // up while the next set is already being offered.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each accepted result against the oldest owed one, field by field.
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    sorted_res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %0h last=%0b ovf=%0b",
                 $time, sorted_value, last_result, overflowed);
      end else begin
        want = pending_sorted.pop_front();
        check_field("sorted_value", want.val, sorted_value);
        check_field("last_result", want.last, last_result);
        check_field("overflowed", want.ovf, overflowed);
      end
    end
  end

  // Hang detector: any cycle in which a request moves on either side resets it.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_sorted.size());
        $display("heap_sort_descending test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sparse input, heavily stalled output.
    src_idle_pct = 37;
    stall_pct    = 80;
    for (i = 0; i < DIR_N; i++)
      send_request(DIR_ROWS[i].v, DIR_ROWS[i].fin, DIR_ROWS[i].typed,
                   '{DIR_ROWS[i].t_val, DIR_ROWS[i].t_last, DIR_ROWS[i].t_ovf});
    // overflowing set: at least the closing value falls off the end
    send_set($urandom_range(67, 65));
    while (items_sent < 80) send_set(small_set_size());

    // Phase 2: the other way round; one set at or just past capacity.
    src_idle_pct = 80;
    stall_pct    = 37;
    send_set($urandom_range(66, 64));
    while (items_sent < 160) send_set(small_set_size());

    // Phase 3: back to back on both sides, after one long output hold.
    src_idle_pct = 0;
    stall_pct    = 0;
    hold_req     = 1'b1;
    while (items_sent < 230) send_set(small_set_size());
    in_valid <= 1'b0;

    // Drain, then give a stray extra result time to show up.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sorted %0d sets from %0d values (%0d results, largest set %0d),",
             sets_closed, items_sent, results_seen, biggest_set);
    $display("%0d sets overflowed the store, under three idle/stall mixes.",
             overflow_sets);
    if (errors == 0 && pending_sorted.size() == 0) begin
      $display("heap_sort_descending test passed");
    end else begin
      $display("heap_sort_descending test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hsd_pkg.sv
rtl/hsd_store.sv
rtl/hsd_sel.sv
rtl/heap_sort_descending.sv
dv/heap_sort_descending_tb.sv
